// ----- rtl/twac_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twac_pkg : shared types and helpers for the three-way audio crossover
// Sample, coefficient and accumulator widths, register indexes, saturation.
// ----------------------------------------------------------------------------
package twac_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 30;
  localparam int COEF_BITS      = 31;
  // feedback a1 = 2*(lp - hp): one sign bit and one doubling bit on top
  localparam int A1_BITS        = COEF_BITS + 2;
  // x +/- 2*x1 + x2 needs two extra bits
  localparam int XS_BITS        = SAMPLE_BITS + 2;
  // largest product is (COEF_BITS+1) x XS_BITS; headroom for the three-term sum
  localparam int ACC_BITS       = COEF_BITS + XS_BITS + 4;
  localparam int CFG_IDX_BITS   = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic        [COEF_BITS-1:0]   coef_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam acc_t    ROUND_HALF = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THREE_WAY      = 3'd0,
    REG_LOW_LP_GAIN    = 3'd1,
    REG_LOW_HP_GAIN    = 3'd2,
    REG_LOW_POLE2      = 3'd3,
    REG_HIGH_LP_GAIN   = 3'd4,
    REG_HIGH_HP_GAIN   = 3'd5,
    REG_HIGH_POLE2     = 3'd6
  } cfg_reg_e;

  // Coefficients for one biquad section
  typedef struct packed {
    coef_t                     gain;   // b0; b1 = +/-2*b0, b2 = b0
    logic                      hp;     // highpass: b1 = -2*b0
    logic signed [A1_BITS-1:0] a1;
    coef_t                     a2;
  } lane_coef_t;

  // Saturate a wide value to a sample
  function automatic sample_t sat_acc(acc_t v);
    logic [ACC_BITS-SAMPLE_BITS:0] top;
    top = v[ACC_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[ACC_BITS-1]) begin
      return SAMPLE_MIN;
    end else begin
      return SAMPLE_MAX;
    end
  endfunction

  // Negate with saturation at the negative limit
  function automatic sample_t neg_sat(sample_t s);
    if (s == SAMPLE_MIN) begin
      return SAMPLE_MAX;
    end else begin
      return -s;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/twac_sample_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twac_sample_if : input sample channel
// Valid/ready channel carrying one signed audio sample per transaction.
// ----------------------------------------------------------------------------
interface twac_sample_if;
  logic              valid;
  logic              ready;
  twac_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

// ----- rtl/twac_bands_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twac_bands_if : output band channel
// Valid/ready channel carrying bass, mid and treble per transaction.
// ----------------------------------------------------------------------------
interface twac_bands_if;
  logic              valid;
  logic              ready;
  twac_pkg::sample_t bass_out;
  twac_pkg::sample_t mid_out;
  twac_pkg::sample_t treble_out;

  modport source (output valid, output bass_out, output mid_out, output treble_out,
                  input ready);
  modport sink   (input valid, input bass_out, input mid_out, input treble_out,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/twac_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twac_cfg_if : configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface twac_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [twac_pkg::CFG_IDX_BITS-1:0]   index;
  logic [twac_pkg::COEF_BITS-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/twac_biquad.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twac_biquad : one second-order section with its delay line
// Computes the rounded, saturated output in one pass; history steps on en_i.
// ----------------------------------------------------------------------------
module twac_biquad (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  twac_pkg::sample_t    x_i,
  input  twac_pkg::lane_coef_t coef_i,
  output twac_pkg::sample_t    y_o,
  output twac_pkg::sample_t    y_prev_o
);

  twac_pkg::sample_t x1_q, x2_q, y1_q, y2_q;

  logic signed [twac_pkg::XS_BITS-1:0]   x_e, x1_dbl, x2_e, xsum;
  logic signed [twac_pkg::COEF_BITS:0]   gain_s, a2_s;
  twac_pkg::acc_t                         prod_b, prod_a1, prod_a2, acc;
  twac_pkg::acc_t                         shifted;

  // b-side factored: g * (x +/- 2*x1 + x2)
  assign x_e    = twac_pkg::XS_BITS'(x_i);
  assign x2_e   = twac_pkg::XS_BITS'(x2_q);
  assign x1_dbl = twac_pkg::XS_BITS'(x1_q) <<< 1;
  assign xsum   = coef_i.hp ? (x_e - x1_dbl + x2_e) : (x_e + x1_dbl + x2_e);

  assign gain_s = {1'b0, coef_i.gain};
  assign a2_s   = {1'b0, coef_i.a2};

  assign prod_b  = twac_pkg::ACC_BITS'(gain_s * xsum);
  assign prod_a1 = twac_pkg::ACC_BITS'(coef_i.a1 * y1_q);
  assign prod_a2 = twac_pkg::ACC_BITS'(a2_s * y2_q);

  assign acc     = prod_b - prod_a1 - prod_a2 + twac_pkg::ROUND_HALF;
  assign shifted = acc >>> twac_pkg::COEF_FRAC_BITS;
  assign y_o     = twac_pkg::sat_acc(shifted);

  assign y_prev_o = y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (en_i) begin
      x2_q <= x1_q;
      x1_q <= x_i;
      y2_q <= y1_q;
      y1_q <= y_o;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/three_way_audio_crossover.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// three_way_audio_crossover : 12 dB/oct three-way crossover, 24-bit audio
// Four biquad sections split one sample stream into bass, mid and treble.
// ----------------------------------------------------------------------------
// Usage
//   sample_i : one signed sample per transaction (valid/ready).
//   bands_o  : bass, mid and treble per transaction (valid/ready).
//   cfg_i    : register writes, index 0 = three_way, 1..6 = split coefficients
//              (Q1.30, unsigned). Always ready; indexes beyond the list are dropped.
//              Write only while no sample is in flight.
// Path: an input transaction lands in the input register, then the filter pass
//   writes the output register, which drives bands_o.valid.
// Throughput: one sample per cycle while bands_o takes each result; the limit is
//   the feedback loop from each section's history through multipliers and accumulator.
// Stall: when bands_o is held off, the output register keeps its transaction,
//   the input register fills, and sample_i.ready drops only once both are full.
// Reset: all filter history and registers clear to zero; two-way mode, all
//   coefficients zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module three_way_audio_crossover (
  input  wire              clk_i,
  input  wire              rst_ni,
  twac_sample_if.sink      sample_i,
  twac_bands_if.source     bands_o,
  twac_cfg_if.sink         cfg_i
);

  // Configuration registers
  logic                  three_way_q;
  twac_pkg::coef_t       low_lp_q, low_hp_q, low_pole2_q;
  twac_pkg::coef_t       high_lp_q, high_hp_q, high_pole2_q;

  // Derived feedback a1 per split: 2*(lp - hp)
  logic signed [twac_pkg::A1_BITS-1:0] low_a1, high_a1;

  // Input register
  logic              s1_valid_q;
  twac_pkg::sample_t s1_sample_q;

  // Output register
  logic              out_valid_q;
  twac_pkg::sample_t bass_q, mid_q, treble_q;

  logic              advance;
  twac_pkg::sample_t y_bass, y_lowhp, y_lowhp_prev, y_mid, y_treble;
  twac_pkg::sample_t unused_prev0, unused_prev2, unused_prev3;
  twac_pkg::lane_coef_t coef_bass, coef_lowhp, coef_mid, coef_treble;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_way_q  <= 1'b0;
      low_lp_q     <= '0;
      low_hp_q     <= '0;
      low_pole2_q  <= '0;
      high_lp_q    <= '0;
      high_hp_q    <= '0;
      high_pole2_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        twac_pkg::REG_THREE_WAY:    three_way_q  <= cfg_i.data[0];
        twac_pkg::REG_LOW_LP_GAIN:  low_lp_q     <= cfg_i.data;
        twac_pkg::REG_LOW_HP_GAIN:  low_hp_q     <= cfg_i.data;
        twac_pkg::REG_LOW_POLE2:    low_pole2_q  <= cfg_i.data;
        twac_pkg::REG_HIGH_LP_GAIN: high_lp_q    <= cfg_i.data;
        twac_pkg::REG_HIGH_HP_GAIN: high_hp_q    <= cfg_i.data;
        twac_pkg::REG_HIGH_POLE2:   high_pole2_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Difference of two unsigned gains fits a signed 32-bit value; doubled, 33.
  assign low_a1  = (twac_pkg::A1_BITS'(low_lp_q)  - twac_pkg::A1_BITS'(low_hp_q))  << 1;
  assign high_a1 = (twac_pkg::A1_BITS'(high_lp_q) - twac_pkg::A1_BITS'(high_hp_q)) << 1;

  assign coef_bass   = '{gain: low_lp_q,  hp: 1'b0, a1: low_a1,  a2: low_pole2_q};
  assign coef_lowhp  = '{gain: low_hp_q,  hp: 1'b1, a1: low_a1,  a2: low_pole2_q};
  assign coef_mid    = '{gain: high_lp_q, hp: 1'b0, a1: high_a1, a2: high_pole2_q};
  assign coef_treble = '{gain: high_hp_q, hp: 1'b1, a1: high_a1, a2: high_pole2_q};

  // ---------------------------------------------------------------------
  // Handshake: input register -> filter pass -> output register
  // ---------------------------------------------------------------------
  assign advance        = s1_valid_q && (!out_valid_q || bands_o.ready);
  assign sample_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (bands_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_sample_q <= '0;
      bass_q      <= '0;
      mid_q       <= '0;
      treble_q    <= '0;
    end else begin
      if (sample_i.ready && sample_i.valid) begin
        s1_sample_q <= sample_i.sample_in;
      end
      if (advance) begin
        bass_q   <= y_bass;
        mid_q    <= three_way_q ? twac_pkg::neg_sat(y_mid) : '0;
        treble_q <= three_way_q ? y_treble : twac_pkg::neg_sat(y_treble);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Filter sections; history steps only when a transaction moves through
  // ---------------------------------------------------------------------
  twac_biquad u_bass (
    .clk_i, .rst_ni, .en_i(advance), .x_i(s1_sample_q), .coef_i(coef_bass),
    .y_o(y_bass), .y_prev_o(unused_prev0)
  );

  twac_biquad u_lowhp (
    .clk_i, .rst_ni, .en_i(advance), .x_i(s1_sample_q), .coef_i(coef_lowhp),
    .y_o(y_lowhp), .y_prev_o(y_lowhp_prev)
  );

  // Mid lowpass runs on the low-split highpass output of the previous sample
  twac_biquad u_mid (
    .clk_i, .rst_ni, .en_i(advance), .x_i(y_lowhp_prev), .coef_i(coef_mid),
    .y_o(y_mid), .y_prev_o(unused_prev2)
  );

  twac_biquad u_treble (
    .clk_i, .rst_ni, .en_i(advance), .x_i(s1_sample_q), .coef_i(coef_treble),
    .y_o(y_treble), .y_prev_o(unused_prev3)
  );

  assign bands_o.valid      = out_valid_q;
  assign bands_o.bass_out   = bass_q;
  assign bands_o.mid_out    = mid_q;
  assign bands_o.treble_out = treble_q;

`ifndef NO_ASSERTIONS
  // An empty output register never holds off the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> sample_i.ready)
    else $error("input stalled with empty output register");

  // A filter pass always lands in the output register
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("filter pass lost");

  // A held input transaction keeps its sample
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_sample_q)))
    else $error("held input sample changed");
`endif

endmodule
`default_nettype wire
